@@ rtl/core/sha256_pkg.sv @@
// Shared types, constants and functions of the SHA-256 message hasher.
// Depends on nothing; every other file of the block imports it.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_done;
  } out_item_t;

  // Control from the byte sequencer to the compression core.
  typedef struct packed {
    logic load_word;
    logic start;
    logic reinit;
  } core_ctl_t;

  localparam int unsigned WordCount  = 8;
  localparam int unsigned RoundCount = 64;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/sha256_in_if.sv @@
// Byte input channel of the SHA-256 message hasher: valid, ready, payload.
// Depends on sha256_pkg for the payload type.
interface sha256_in_if;
  import sha256_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/sha256_out_if.sv @@
// Digest output channel of the SHA-256 message hasher: valid, ready, payload.
// Depends on sha256_pkg for the payload type.
interface sha256_out_if;
  import sha256_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/sha256_core.sv @@
// SHA-256 compression core: message schedule window, round unit and chaining value.
// Depends on sha256_pkg for the round constants, initial hash and control struct.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::core_ctl_t ctl,
  input  logic [31:0]           word,
  input  logic [2:0]            rd_idx,
  output logic [31:0]           rd_word,
  output logic                  busy
);
  import sha256_pkg::*;

  logic [31:0] chain [WordCount];
  logic [31:0] vars [WordCount];
  logic [31:0] win [16];
  logic [5:0]  round;
  logic        run;
  logic        fin;

  logic [31:0] s0_big, s1_big, ch, maj, t1, t2;
  logic [31:0] s0_small, s1_small, w_new;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One round of the compression function and one schedule word.
  always_comb begin
    s1_big   = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    ch       = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    t1       = vars[7] + s1_big + ch + round_k(round) + win[0];
    s0_big   = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    maj      = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t2       = s0_big + maj;
    s0_small = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1_small = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    w_new    = s1_small + win[9] + s0_small + win[0];
  end

  assign busy    = run | fin;
  assign rd_word = chain[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      fin   <= 1'b0;
      round <= '0;
    end else begin
      if (ctl.start) begin
        run   <= 1'b1;
        round <= '0;
      end else if (run) begin
        round <= round + 6'd1;
        if (round == 6'(RoundCount - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else begin
        fin <= 1'b0;
      end
    end
  end

  // The window is a shift line: word 0 is always the schedule word of this round.
  always_ff @(posedge clk) begin
    if (ctl.load_word || run) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= ctl.load_word ? word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < WordCount; i++) begin
        vars[i] <= chain[i];
      end
    end else if (run) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reinit) begin
      for (int i = 0; i < WordCount; i++) begin
        chain[i] <= init_hash(3'(i));
      end
    end else if (fin) begin
      for (int i = 0; i < WordCount; i++) begin
        chain[i] <= chain[i] + vars[i];
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !busy)
    else $error("compression started while the core was busy");

  a_last_round: assert property (@(posedge clk) disable iff (rst)
    (run && round == 6'(RoundCount - 1)) |=> (fin && !run))
    else $error("final round did not lead to the chaining update");

  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    fin |=> !busy)
    else $error("chaining update lasted more than one cycle");

endmodule

@@ rtl/core/sha256_message_hasher.sv @@
// Top level of the SHA-256 message hasher: byte packing, padding sequencer, digest output.
// Depends on sha256_pkg, sha256_in_if, sha256_out_if and sha256_core.
//
// Use: message bytes enter on msg, one byte per transfer, most significant byte
// of each big-endian word first; final_byte marks the last byte of a message.
// The 256-bit digest leaves on digest as eight 32-bit transfers, word 0 first,
// with digest_done set on word 7. Every message holds at least one byte.
//
// Flow: the byte that completes a 64-byte block starts the compression
// core, which loads the working variables at the accepting edge, then runs
// the 64 rounds (one round per cycle through a single shared round unit),
// adds into the chaining value and hands the byte path back to the
// sequencer; msg.ready stays low from the accepting edge until then. After the
// final byte the padding bytes (0x80, zero fill, 64-bit bit length) are fed
// one per cycle, except while a compression runs, through the same byte path:
// up to 72 bytes and one or two further compressions; then the eight digest
// words are offered one per cycle while the receiver is ready.
// Only one message is in flight: msg.ready is high only while bytes are taken.
//
// Reset (synchronous, active high) restores the initial hash and clears the
// byte position, the byte count and the sequencer. If the receiver stalls, the
// current digest word stays on the port unchanged and nothing further is taken
// until all eight words have been transferred; the initial hash is then restored.
module sha256_message_hasher (
  input logic         clk,
  input logic         rst,
  sha256_in_if.sink   msg,
  sha256_out_if.source digest
);
  import sha256_pkg::*;

  localparam logic [1:0] ST_IN   = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_HASH = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  localparam logic [5:0] LenStart = 6'd56;

  logic [1:0]  state, state_next;
  logic [1:0]  phase;
  logic [2:0]  len_idx;
  logic        padding;
  logic        pad_done;
  logic [5:0]  pos;
  logic [23:0] partial;
  logic [60:0] count;
  logic [2:0]  out_idx;

  logic        in_fire, out_fire;
  logic        absorb_en, block_full, is_len, pad_last;
  logic [7:0]  pad_byte, absorb_byte;
  logic [63:0] len_bits;
  logic        core_busy;
  logic [31:0] core_word;
  core_ctl_t   ctl;

  assign in_fire  = msg.valid && msg.ready;
  assign out_fire = digest.valid && digest.ready;

  assign msg.ready    = (state == ST_IN);
  assign digest.valid = (state == ST_OUT);
  assign digest.payload.digest_word = core_word;
  assign digest.payload.word_number = out_idx;
  assign digest.payload.digest_done = (out_idx == 3'(WordCount - 1));

  // Padding byte source. Once the zero fill reaches byte 56 the length bytes follow.
  assign len_bits = {count, 3'b000};
  assign is_len   = (phase == PH_LEN) || (phase == PH_ZERO && pos == LenStart);
  assign pad_last = (state == ST_PAD) && is_len && (len_idx == 3'd0);

  always_comb begin
    if (phase == PH_MARK) begin
      pad_byte = 8'h80;
    end else if (is_len) begin
      pad_byte = len_bits[{len_idx, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign absorb_en   = in_fire || (state == ST_PAD);
  assign absorb_byte = in_fire ? msg.payload.data_byte : pad_byte;
  assign block_full  = absorb_en && (pos == 6'd63);

  assign ctl.load_word = absorb_en && (pos[1:0] == 2'b11);
  assign ctl.start     = block_full;
  assign ctl.reinit    = out_fire && (out_idx == 3'(WordCount - 1));

  sha256_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .word    ({partial, absorb_byte}),
    .rd_idx  (out_idx),
    .rd_word (core_word),
    .busy    (core_busy)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IN: begin
        if (in_fire) begin
          if (block_full) begin
            state_next = ST_HASH;
          end else if (msg.payload.final_byte) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (block_full) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (!core_busy) begin
          if (pad_done) begin
            state_next = ST_OUT;
          end else if (padding) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_IN;
          end
        end
      end
      ST_OUT: begin
        if (ctl.reinit) begin
          state_next = ST_IN;
        end
      end
      default: state_next = ST_IN;
    endcase
  end

  // The word under assembly only needs its three older bytes kept.
  always_ff @(posedge clk) begin
    if (absorb_en) begin
      partial <= {partial[15:0], absorb_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IN;
      phase    <= PH_MARK;
      len_idx  <= 3'd7;
      padding  <= 1'b0;
      pad_done <= 1'b0;
      pos      <= '0;
      count    <= '0;
      out_idx  <= '0;
    end else begin
      state <= state_next;
      if (absorb_en) begin
        pos <= pos + 6'd1;
      end
      if (in_fire) begin
        count <= count + 61'd1;
        if (msg.payload.final_byte) begin
          padding <= 1'b1;
          phase   <= PH_MARK;
          len_idx <= 3'd7;
        end
      end
      if (state == ST_PAD) begin
        if (phase == PH_MARK) begin
          phase <= PH_ZERO;
        end else if (is_len) begin
          phase   <= PH_LEN;
          len_idx <= len_idx - 3'd1;
          if (len_idx == 3'd0) begin
            pad_done <= 1'b1;
          end
        end
      end
      if (out_fire) begin
        if (ctl.reinit) begin
          padding  <= 1'b0;
          pad_done <= 1'b0;
          count    <= '0;
          pos      <= '0;
          out_idx  <= '0;
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  a_len_at_boundary: assert property (@(posedge clk) disable iff (rst)
    pad_last |-> block_full)
    else $error("length field did not end on a block boundary");

  a_out_core_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> !core_busy)
    else $error("digest offered while a compression was running");

  a_start_word: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> ctl.load_word)
    else $error("block started without its last word");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the SHA-256 message hasher: byte stimulus, a
// digest predictor held in a small scoreboard class, and digest word checks.
// Depends on sha256_pkg, sha256_in_if, sha256_out_if and sha256_message_hasher.
`timescale 1ns / 100ps

module tb_top;
  import sha256_pkg::*;

  // The watchdog ends the run after this many cycles without a transfer on
  // either channel. The longest quiet stretch in a correct run is the tail of
  // a message: up to 72 padding bytes and two compressions, plus a receiver
  // stall. This margin is ample for it.
  localparam int unsigned QuietLimit = 2000;

  // Cycles allowed after the last expected word, so that a stray extra word
  // from the block still has time to appear and be flagged.
  localparam int unsigned DrainCycles = 250;

  // Target number of message bytes in the random part.
  localparam int unsigned RandomBytes = 390;

  // SHA-256 initial hash and round constants, index 0 first.
  localparam logic [0:7][31:0] HashInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // The scoreboard keeps its own copy of the hashing state. Each accepted byte
  // is absorbed into it; a final byte runs the padding through the same path
  // and queues the eight digest words that the block should then send.
  class digest_tracker;
    logic [31:0] chain[8];
    logic [31:0] sched[16];
    logic [31:0] partial;
    int unsigned pos;
    logic [60:0] byte_count;
    out_item_t   expected_words[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) begin
        chain[i] = HashInit[i];
      end
      partial    = '0;
      pos        = 0;
      byte_count = '0;
    endfunction

    function logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] v[8];
      logic [31:0] w2, w15, s0, s1, t1, t2;
      for (int i = 0; i < 8; i++) begin
        v[i] = chain[i];
      end
      for (int t = 0; t < 64; t++) begin
        // From round 16 on the window rolls: each slot is replaced by the
        // next schedule word in place.
        if (t >= 16) begin
          w2  = sched[(t - 2) % 16];
          w15 = sched[(t - 15) % 16];
          s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
          s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
          sched[t % 16] = s1 + sched[(t - 7) % 16] + s0 + sched[t % 16];
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + sched[t % 16];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
        chain[i] = chain[i] + v[i];
      end
    endfunction

    // Packs one byte big-endian into the current word and block.
    function void absorb(input logic [7:0] b);
      partial = {partial[23:0], b};
      pos++;
      if (pos % 4 == 0) begin
        sched[pos / 4 - 1] = partial;
        partial = '0;
      end
      if (pos == 64) begin
        compress();
        pos = 0;
      end
    endfunction

    function void note_byte(input in_item_t item);
      logic [63:0] bit_len;
      out_item_t   word;
      absorb(item.data_byte);
      byte_count = byte_count + 61'd1;
      if (item.final_byte) begin
        absorb(8'h80);
        while (pos != 56) begin
          absorb(8'h00);
        end
        bit_len = {byte_count, 3'b000};
        for (int i = 7; i >= 0; i--) begin
          absorb(bit_len[8 * i +: 8]);
        end
        for (int i = 0; i < 8; i++) begin
          word.digest_word = chain[i];
          word.word_number = i[2:0];
          word.digest_done = (i == 7);
          expected_words = {expected_words, word};
        end
        restart();
      end
    endfunction

    function void check_word(input out_item_t got);
      out_item_t want;
      if (expected_words.size() == 0) begin
        $error("digest word %h arrived with no word expected", got.digest_word);
        fail_count++;
        return;
      end
      want = expected_words.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
        fail_count++;
      end
      if (got.word_number !== want.word_number) begin
        $error("word_number: expected %0d, actual %0d", want.word_number, got.word_number);
        fail_count++;
      end
      if (got.digest_done !== want.digest_done) begin
        $error("digest_done: expected %b, actual %b", want.digest_done, got.digest_done);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sha256_in_if  msg_if ();
  sha256_out_if digest_if ();

  sha256_message_hasher u_top (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (digest_if)
  );

  digest_tracker tracker;

  // Idling switches for the sender and the receiver. Both are cleared for
  // the last stretch of the run so that it goes at full rate.
  bit gaps_on   = 1'b0;
  bit stalls_on = 1'b0;

  int unsigned quiet_cycles;
  int unsigned random_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sends one byte. A random gap may come first, with valid low; then the
  // byte is held on the port until the transfer completes.
  task automatic send_byte(input logic [7:0] value, input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      msg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    msg_if.valid   <= 1'b1;
    msg_if.payload <= '{data_byte: value, final_byte: last};
    do @(posedge clk); while (!msg_if.ready);
  endtask

  // Sends a whole message of random content, final_byte on its last byte.
  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // The length mix leans towards short messages, which keep the run quick,
  // but regularly lands on the padding boundaries: 55 bytes still fits the
  // length field in the same block, 56 pushes it into a second one, and 64
  // leaves a block made of padding alone. Longer messages span one or two
  // compressions before padding starts.
  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      6: begin
        return $urandom_range(55, 57);
      end
      7: begin
        return $urandom_range(63, 65);
      end
      8: begin
        return $urandom_range(100, 130);
      end
      9: begin
        return $urandom_range(21, 54);
      end
      default: begin
        return $urandom_range(1, 20);
      end
    endcase
  endfunction

  // The receiver: ready is dropped in random bursts while stalls are on,
  // and held high otherwise.
  initial begin
    digest_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        digest_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        digest_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Transfers are sampled at the rising edge, before any of this edge's
  // nonblocking updates land, so the values seen are those the block saw.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (msg_if.valid && msg_if.ready) begin
        tracker.note_byte(msg_if.payload);
      end
      if (digest_if.valid && digest_if.ready) begin
        tracker.check_word(digest_if.payload);
      end
      if ((msg_if.valid && msg_if.ready) || (digest_if.valid && digest_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    tracker = new();
    quiet_cycles = 0;
    rst <= 1'b1;
    msg_if.valid <= 1'b0;
    msg_if.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at full rate. The three-byte text "abc" is the classic
    // test vector. Single bytes of all zeros and all ones give the shortest
    // possible messages at both extremes of the data field. A run of sixteen
    // 0xff bytes fills whole words with ones, and the alternating patterns
    // toggle every bit against its neighbour.
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < 16; i++) begin
      send_byte(8'hff, i == 15);
    end
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);

    // Random part. Idling is switched per message so that some messages run
    // with gaps and stalls throughout and others run clean; the last stretch
    // has no idling at all.
    random_sent = 0;
    while (random_sent < RandomBytes) begin
      if (random_sent < RandomBytes * 4 / 5) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end else begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      begin
        int unsigned len;
        len = pick_length();
        send_message(len);
        random_sent += len;
      end
    end
    msg_if.valid <= 1'b0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;

    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
